// ----- rtl/speech_segment_detector_defines.svh -----
// Assertion macros for the speech segment detector checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SPEECH_SEGMENT_DETECTOR_DEFINES_SVH
`define SPEECH_SEGMENT_DETECTOR_DEFINES_SVH

// Checked only out of reset
`define SSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included
`define SSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/ssd_pkg.sv -----
// Shared types, register codes and constants for the speech segment detector.
// No dependencies.
package ssd_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned PosW     = 32;
  localparam int unsigned ProbW    = 16;
  localparam int unsigned WinW     = 13;
  localparam int unsigned LenW     = 20;
  // 20 * 65535 fits in 21 bits
  localparam int unsigned ScaledW  = 21;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_WINDOW      = 2'd1,
    REG_MIN_SILENCE = 2'd2,
    REG_MIN_SPEECH  = 2'd3
  } ssd_reg_e;

  // Register reset values
  localparam logic [ProbW-1:0] ThresholdRst  = 16'd32768;
  localparam logic [WinW-1:0]  WindowRst     = 13'd512;
  localparam logic [LenW-1:0]  MinSilenceRst = 20'd1600;
  localparam logic [LenW-1:0]  MinSpeechRst  = 20'd32000;

  // Low threshold in units of 1/20: max(20t - 0.15*20*2^16, 0.1*20*2^16)
  localparam logic [ScaledW-1:0] LowOffset = 21'd196608;
  localparam logic [ScaledW-1:0] LowFloor  = 21'd131072;
  localparam logic [ScaledW-1:0] LowKnee   = 21'd327680;

  typedef struct packed {
    logic [ProbW-1:0] win_prob;
    logic             continue_segment;
  } ssd_in_t;

  typedef struct packed {
    logic            speaking;
    logic [PosW-1:0] segment_start;
    logic [PosW-1:0] segment_end;
    logic            segment_closed;
    logic [PosW-1:0] position;
  } ssd_out_t;

  typedef struct packed {
    logic [ProbW-1:0] threshold;
    logic [WinW-1:0]  window;
    logic [LenW-1:0]  min_silence;
    logic [LenW-1:0]  min_speech;
  } ssd_cfg_t;

  // x * 20 as two shifts and an add
  function automatic logic [ScaledW-1:0] times20(input logic [ProbW-1:0] x);
    logic [ScaledW-1:0] xe;
    xe = ScaledW'(x);
    return (xe << 4) + (xe << 2);
  endfunction

endpackage

// ----- rtl/ssd_cfg_regs.sv -----
// Configuration register file of the speech segment detector.
// Depends on ssd_pkg.
module ssd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ssd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output ssd_pkg::ssd_cfg_t              cfg_o
);
  import ssd_pkg::*;

  ssd_cfg_t cfg_q;
  ssd_reg_e reg_sel;

  assign reg_sel = ssd_reg_e'(cfg_index_i);

  // Register writes, each truncated to its field width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold   <= ThresholdRst;
      cfg_q.window      <= WindowRst;
      cfg_q.min_silence <= MinSilenceRst;
      cfg_q.min_speech  <= MinSpeechRst;
    end else if (cfg_we_i) begin
      unique case (reg_sel)
        REG_THRESHOLD:   cfg_q.threshold   <= cfg_wdata_i[ProbW-1:0];
        REG_WINDOW:      cfg_q.window      <= cfg_wdata_i[WinW-1:0];
        REG_MIN_SILENCE: cfg_q.min_silence <= cfg_wdata_i[LenW-1:0];
        REG_MIN_SPEECH:  cfg_q.min_speech  <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/ssd_core.sv -----
// Segmenter state and next-state logic: position, open flag, start/end and
// silence marks. Depends on ssd_pkg.
module ssd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  ssd_pkg::ssd_in_t   item_i,
  input  ssd_pkg::ssd_cfg_t  cfg_i,
  output ssd_pkg::ssd_out_t  res_o
);
  import ssd_pkg::*;

  logic            open_q, open_d;
  logic            sil_valid_q, sil_valid_d;
  logic [PosW-1:0] sil_mark_q, sil_mark_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] start_q, start_d;
  logic [PosW-1:0] end_q, end_d;
  logic            closed;

  logic               is_speech;
  logic               is_silence;
  logic [ScaledW-1:0] p20;
  logic [ScaledW-1:0] t20;
  logic [ScaledW-1:0] low;
  logic [PosW-1:0]    mark_eff;
  logic [PosW-1:0]    speech_len;
  logic [PosW-1:0]    silence_len;

  // Hysteresis thresholds, exact in units of 1/20
  assign p20        = times20(item_i.win_prob);
  assign t20        = times20(cfg_i.threshold);
  assign low        = (t20 > LowKnee) ? (t20 - LowOffset) : LowFloor;
  assign is_speech  = item_i.win_prob >= cfg_i.threshold;
  assign is_silence = p20 < low;

  assign pos_d       = pos_q + PosW'(cfg_i.window);
  assign speech_len  = pos_d - start_q;
  assign mark_eff    = sil_valid_q ? sil_mark_q : pos_d;
  assign silence_len = pos_d - mark_eff;

  // Segment decisions for this window
  always_comb begin
    open_d      = open_q;
    sil_valid_d = sil_valid_q;
    sil_mark_d  = sil_mark_q;
    start_d     = start_q;
    end_d       = end_q;
    closed      = 1'b0;
    if (is_speech) begin
      sil_valid_d = 1'b0;
      sil_mark_d  = '0;
      if (!open_q) begin
        open_d = 1'b1;
        if (!item_i.continue_segment) begin
          start_d = pos_q;
          end_d   = '0;
        end
      end
    end else if (is_silence && open_q) begin
      if (speech_len >= PosW'(cfg_i.min_speech)) begin
        if (silence_len >= PosW'(cfg_i.min_silence)) begin
          end_d       = mark_eff;
          sil_valid_d = 1'b0;
          sil_mark_d  = '0;
          open_d      = 1'b0;
          closed      = 1'b1;
        end else begin
          sil_valid_d = 1'b1;
          sil_mark_d  = mark_eff;
        end
      end
    end
  end

  // State update on each processed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      sil_valid_q <= 1'b0;
      sil_mark_q  <= '0;
      pos_q       <= '0;
      start_q     <= '0;
      end_q       <= '0;
    end else if (step_i) begin
      open_q      <= open_d;
      sil_valid_q <= sil_valid_d;
      sil_mark_q  <= sil_mark_d;
      pos_q       <= pos_d;
      start_q     <= start_d;
      end_q       <= end_d;
    end
  end

  assign res_o.speaking       = open_d;
  assign res_o.segment_start  = start_d;
  assign res_o.segment_end    = end_d;
  assign res_o.segment_closed = closed;
  assign res_o.position       = pos_d;

endmodule

// ----- rtl/speech_segment_detector.sv -----
// Top level of the speech segment detector: input register, segmenter core,
// result register. Depends on ssd_pkg, ssd_cfg_regs and ssd_core.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o   | in_data_i  (ssd_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (ssd_out_t)
//  cfg     | input     | cfg_we_i (no stall)     | cfg_index_i, cfg_wdata_i
//
// One request per cycle sustained while the output is not stalled; a taken
// request passes the input register, then the result register, to the output.
// The segmenter state updates once per request as it moves from the input
// register into the result register.
// A stalled result holds both stages; the input side stays ready while the
// input register is empty. Reset clears all but the two data registers.
module speech_segment_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ssd_pkg::ssd_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ssd_pkg::ssd_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [ssd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ssd_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import ssd_pkg::*;

  ssd_cfg_t cfg;
  ssd_in_t  in_data_q;
  logic     in_valid_q;
  ssd_out_t res;
  ssd_out_t out_data_q;
  logic     out_valid_q;
  logic     advance;
  logic     step;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign step       = in_valid_q && advance;

  ssd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/ssd_checker.sv -----
// Port-level checker for the speech segment detector, bound to the top level.
// Depends on ssd_pkg and speech_segment_detector_defines.svh.
`include "speech_segment_detector_defines.svh"

module ssd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_ready_o,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  ssd_pkg::ssd_out_t             out_data_o
);
  import ssd_pkg::*;

  // No result while in reset
  `SSD_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "result valid in reset")

  // A stalled result holds
  `SSD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // A window that closes a segment leaves it closed
  `SSD_ASSERT(a_closed_not_speaking, out_valid_o && out_data_o.segment_closed |-> !out_data_o.speaking, "closed while speaking")

  // An empty result stage never stalls the input
  `SSD_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input stalled with no result pending")

endmodule

bind speech_segment_detector ssd_checker u_ssd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
